// ===== rtl/lik_pkg.sv =====
// ----------------------------------------------------------------------------
// lik_pkg
// Shared widths, latencies, angle table and rounding for the leg IK pipeline.
// ----------------------------------------------------------------------------
package lik_pkg;

  // CORDIC iteration count and table length
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;

  // CORDIC widths: input vector, internal datapath, angle (2^-24 rad)
  localparam int unsigned CIW  = 18;
  localparam int unsigned XW   = 46;
  localparam int unsigned AW   = 28;
  localparam int unsigned FRAC = 24;
  localparam int unsigned CORDIC_LAT = CORDIC_STEPS + 1;

  // square root: 32 bit radicand, 16 bit root, one result bit per stage
  localparam int unsigned SQ_IW    = 32;
  localparam int unsigned SQ_OW    = 16;
  localparam int unsigned SQRT_LAT = SQ_OW;

  // cosine quotient: operand width and quotient width, one bit per stage
  localparam int unsigned DW      = 34;
  localparam int unsigned QW      = 15;
  localparam int unsigned DIV_LAT = QW;

  localparam int ONE_Q14 = 16384;
  localparam logic signed [AW-1:0] PI_S24 = AW'(52707179);

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_COXA  = 2'd0;
  localparam reg_idx_t REG_FEMUR = 2'd1;
  localparam reg_idx_t REG_TIBIA = 2'd2;

  // side info that travels with a quotient: clamped, negative
  typedef struct packed {
    logic spec;
    logic neg;
  } cos_side_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic signed [AW-1:0] atan_s24(input int unsigned i);
    logic signed [AW-1:0] r;
    unique case (i)
      0:  r = AW'(13176795);
      1:  r = AW'(7778716);
      2:  r = AW'(4110060);
      3:  r = AW'(2086331);
      4:  r = AW'(1047214);
      5:  r = AW'(524117);
      6:  r = AW'(262123);
      7:  r = AW'(131069);
      8:  r = AW'(65536);
      9:  r = AW'(32768);
      10: r = AW'(16384);
      11: r = AW'(8192);
      12: r = AW'(4096);
      13: r = AW'(2048);
      14: r = AW'(1024);
      15: r = AW'(512);
      16: r = AW'(256);
      17: r = AW'(128);
      18: r = AW'(64);
      19: r = AW'(32);
      20: r = AW'(16);
      21: r = AW'(8);
      22: r = AW'(4);
      23: r = AW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // 2^-24 rad to Q3.13, round half up, saturate
  function automatic logic signed [15:0] to_q13(input logic signed [AW:0] a);
    logic signed [AW+1:0] s;
    logic signed [AW+1:0] q;
    logic signed [15:0]   r;
    s = (AW+2)'(a) + (AW+2)'(1024);
    q = s >>> 11;
    if (q > (AW+2)'(32767)) begin
      r = 16'sh7fff;
    end else if (q < -(AW+2)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lik_sqrt.sv =====
// ----------------------------------------------------------------------------
// lik_sqrt
// Pipelined floor square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module lik_sqrt (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [lik_pkg::SQ_IW-1:0]        val_i,
  output logic [lik_pkg::SQ_OW-1:0]        root_o
);

  localparam int unsigned IW = lik_pkg::SQ_IW;
  localparam int unsigned RW = IW + 1;
  localparam int unsigned NS = lik_pkg::SQRT_LAT;

  logic [IW-1:0] rem_q [NS];
  logic [RW-1:0] res_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [RW-1:0] BitVal = RW'(1) << (IW - 2 - 2 * k);
    logic [IW-1:0] rem_in;
    logic [RW-1:0] res_in;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = val_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + BitVal;

    // one restoring step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k] <= rem_in - trial[IW-1:0];
          res_q[k] <= (res_in >> 1) + BitVal;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[NS-1][lik_pkg::SQ_OW-1:0];

endmodule

// ===== rtl/lik_div.sv =====
// ----------------------------------------------------------------------------
// lik_div
// Pipelined restoring divider for the cosine quotient mag * 2^14 / den.
// ----------------------------------------------------------------------------
module lik_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [lik_pkg::DW-1:0]      mag_i,
  input  logic [lik_pkg::DW-1:0]      den_i,
  input  lik_pkg::cos_side_t          side_i,
  output logic [lik_pkg::QW-1:0]      quo_o,
  output lik_pkg::cos_side_t          side_o
);

  localparam int unsigned DW = lik_pkg::DW;
  localparam int unsigned QW = lik_pkg::QW;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NS = lik_pkg::DIV_LAT;

  logic [RW-1:0]      rem_q  [NS];
  logic [DW-1:0]      den_q  [NS];
  logic [QW-1:0]      quo_q  [NS];
  lik_pkg::cos_side_t side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [RW-1:0]      rem_in;
    logic [DW-1:0]      den_in;
    logic [QW-1:0]      quo_in;
    lik_pkg::cos_side_t side_in;
    logic               ge;
    logic [RW-1:0]      diff;
    logic [QW-1:0]      quo_nx;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, mag_i};
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign ge     = rem_in >= {1'b0, den_in};
    assign diff   = ge ? rem_in - {1'b0, den_in} : rem_in;
    assign quo_nx = quo_in | (QW'(ge) << (QW - 1 - k));

    // one quotient bit, remainder doubled for the next
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= {diff[RW-2:0], 1'b0};
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_nx;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = quo_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

// ===== rtl/lik_cordic.sv =====
// ----------------------------------------------------------------------------
// lik_cordic
// Pipelined vectoring CORDIC atan2, one iteration per stage, 2^-24 rad out.
// ----------------------------------------------------------------------------
module lik_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [lik_pkg::CIW-1:0]     y_i,
  input  logic signed [lik_pkg::CIW-1:0]     x_i,
  output logic signed [lik_pkg::AW-1:0]      ang_o
);

  localparam int unsigned CIW = lik_pkg::CIW;
  localparam int unsigned XW  = lik_pkg::XW;
  localparam int unsigned AW  = lik_pkg::AW;
  localparam int unsigned NS  = lik_pkg::CORDIC_STEPS;

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic signed [AW-1:0] a_q [NS+1];
  logic [NS:0]          zero_q;

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic                 left;
  logic                 zero_d;

  assign x_ext  = {{(XW-CIW){x_i[CIW-1]}}, x_i};
  assign y_ext  = {{(XW-CIW){y_i[CIW-1]}}, y_i};
  assign left   = x_i[CIW-1];
  assign zero_d = (x_i == '0) && (y_i == '0);

  // fold left half plane, scale to 2^-24
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (left) begin
        x_q[0] <= (-x_ext) <<< lik_pkg::FRAC;
        y_q[0] <= (-y_ext) <<< lik_pkg::FRAC;
        a_q[0] <= y_i[CIW-1] ? -lik_pkg::PI_S24 : lik_pkg::PI_S24;
      end else begin
        x_q[0] <= x_ext <<< lik_pkg::FRAC;
        y_q[0] <= y_ext <<< lik_pkg::FRAC;
        a_q[0] <= '0;
      end
    end
  end

  // zero vector flag rides along
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= {zero_q[NS-1:0], zero_d};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic signed [AW-1:0] Atan = lik_pkg::atan_s24(k);
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    // rotate toward the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[k][XW-1]) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          a_q[k+1] <= a_q[k] + Atan;
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          a_q[k+1] <= a_q[k] - Atan;
        end
      end
    end
  end

  assign ang_o = zero_q[NS] ? '0 : a_q[NS];

endmodule

// ===== rtl/leg_inverse_kinematics.sv =====
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits at the output.
// Path: radius root, reach root, quotient divider and acos root in series,
// then the acos CORDIC; hip and plane CORDICs run alongside.
// Reset: valid bits cleared, lengths back to 0.05 / 0.10 / 0.15 m.
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// Three-joint leg IK: foot target in, hip, femur and knee angles out.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  lik_pkg::reg_idx_t   cfg_idx_i,
  input  logic [14:0]         cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          leg_tag_i,
  input  logic signed [15:0]  foot_x_i,
  input  logic signed [15:0]  foot_y_i,
  input  logic signed [15:0]  foot_z_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          leg_tag_out_o,
  output logic signed [15:0]  hip_yaw_o,
  output logic signed [15:0]  femur_angle_o,
  output logic signed [15:0]  knee_angle_o,
  output logic                unreachable_o
);

  localparam int unsigned DW  = lik_pkg::DW;
  localparam int unsigned AW  = lik_pkg::AW;
  localparam int unsigned CIW = lik_pkg::CIW;
  localparam int unsigned SL  = lik_pkg::SQRT_LAT;
  localparam int unsigned DL  = lik_pkg::DIV_LAT;
  localparam int unsigned CL  = lik_pkg::CORDIC_LAT;

  // stage numbers
  localparam int unsigned T_RAD   = 2 + SL;
  localparam int unsigned T_PLANE = T_RAD + 1;
  localparam int unsigned T_SUM2  = T_PLANE + 2;
  localparam int unsigned T_REACH = T_SUM2 + SL;
  localparam int unsigned T_NUM   = T_REACH + 2;
  localparam int unsigned T_CLAMP = T_NUM + 1;
  localparam int unsigned T_Q     = T_CLAMP + DL;
  localparam int unsigned T_C     = T_Q + 1;
  localparam int unsigned T_S     = T_C + 2 + SL;
  localparam int unsigned T_ACOS  = T_S + CL;

  localparam int unsigned HIP_D  = T_ACOS - CL;
  localparam int unsigned ZP_D   = T_ACOS - T_PLANE - CL;
  localparam int unsigned CD_N   = T_S - T_C + 1;
  localparam int unsigned FLAG_N = T_ACOS - T_C + 1;

  typedef struct packed {
    lik_pkg::cos_side_t side;
    logic [DW-1:0]      mag;
  } clamp_t;

  // ---------------- configuration ----------------
  logic [14:0] coxa_q, femur_q, tibia_q;
  logic [29:0] ff_q, tt_q, ft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_q  <= 15'd819;
      femur_q <= 15'd1638;
      tibia_q <= 15'd2458;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lik_pkg::REG_COXA:  coxa_q  <= cfg_data_i;
        lik_pkg::REG_FEMUR: femur_q <= cfg_data_i;
        lik_pkg::REG_TIBIA: tibia_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // length products, refreshed every cycle
  always_ff @(posedge clk_i) begin
    ff_q <= 30'(femur_q) * 30'(femur_q);
    tt_q <= 30'(tibia_q) * 30'(tibia_q);
    ft_q <= 30'(femur_q) * 30'(tibia_q);
  end

  // ---------------- pipeline control ----------------
  logic          en;
  logic [T_ACOS:0] vld_q;
  logic          out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[T_ACOS-1:0], in_valid_i};
      out_valid_q <= vld_q[T_ACOS];
    end
  end

  // ---------------- planar radius ----------------
  logic signed [15:0] x0_q, y0_q;
  logic [1:0]         tag_dq [T_ACOS+1];
  logic signed [15:0] z_dq   [T_PLANE+1];
  logic [31:0]        xx_q, yy_q, r2_q;
  logic [15:0]        radius;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q      <= foot_x_i;
      y0_q      <= foot_y_i;
      tag_dq[0] <= leg_tag_i;
      z_dq[0]   <= foot_z_i;
      for (int k = 1; k <= T_ACOS; k++) tag_dq[k] <= tag_dq[k-1];
      for (int k = 1; k <= T_PLANE; k++) z_dq[k] <= z_dq[k-1];
      xx_q <= 32'(x0_q * x0_q);
      yy_q <= 32'(y0_q * y0_q);
      r2_q <= xx_q + yy_q;
    end
  end

  lik_sqrt u_sqrt_rad (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (r2_q),
    .root_o (radius)
  );

  // ---------------- hip yaw ----------------
  logic signed [AW-1:0] hip_ang;
  logic signed [AW-1:0] hip_dq [HIP_D];

  lik_cordic u_cordic_hip (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ({{(CIW-16){y0_q[15]}}, y0_q}),
    .x_i   ({{(CIW-16){x0_q[15]}}, x0_q}),
    .ang_o (hip_ang)
  );

  // ---------------- leg plane and reach ----------------
  logic signed [16:0]    plane_q;
  logic signed [17:0]    plane_d;
  logic signed [CIW-1:0] zneg;
  logic [31:0]           pp_q, zz_q, s2_q;
  logic [15:0]           reach;

  assign plane_d = $signed({2'b0, radius}) - $signed({3'b0, coxa_q});
  assign zneg    = -{{(CIW-16){z_dq[T_PLANE][15]}}, z_dq[T_PLANE]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      plane_q <= plane_d[16:0];
      pp_q    <= 32'(plane_q * plane_q);
      zz_q    <= 32'(z_dq[T_PLANE] * z_dq[T_PLANE]);
      s2_q    <= pp_q + zz_q;
    end
  end

  lik_sqrt u_sqrt_reach (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (s2_q),
    .root_o (reach)
  );

  logic signed [AW-1:0] zp_ang;
  logic signed [AW-1:0] zp_dq [ZP_D];

  lik_cordic u_cordic_plane (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (zneg),
    .x_i   ({plane_q[16], plane_q}),
    .ang_o (zp_ang)
  );

  // ---------------- cosine numerators and denominators ----------------
  logic [31:0]          rr_q;
  logic [30:0]          fr_q;
  logic signed [DW:0]   numk_q, numb_q;
  logic [DW-1:0]        denk_q, denb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q   <= 32'(reach) * 32'(reach);
      fr_q   <= 31'(femur_q) * 31'(reach);
      numk_q <= $signed({5'b0, ff_q}) + $signed({5'b0, tt_q}) - $signed({3'b0, rr_q});
      numb_q <= $signed({5'b0, ff_q}) + $signed({3'b0, rr_q}) - $signed({5'b0, tt_q});
      denk_q <= DW'({ft_q, 1'b0});
      denb_q <= DW'({fr_q, 1'b0});
    end
  end

  // clamp out-of-range arguments and a zero denominator; the magnitude goes to the divider in every case
  function automatic clamp_t cos_prep(input logic signed [DW:0] num,
                                      input logic [DW-1:0] den);
    clamp_t               r;
    logic signed [DW:0]   sd;
    logic signed [DW:0]   an;
    sd = $signed({1'b0, den});
    an = num[DW] ? -num : num;
    r.mag = an[DW-1:0];
    priority if (den == '0) begin
      r.side.spec = 1'b1;
      r.side.neg  = num[DW];
    end else if (num > sd) begin
      r.side.spec = 1'b1;
      r.side.neg  = 1'b0;
    end else if (num < -sd) begin
      r.side.spec = 1'b1;
      r.side.neg  = 1'b1;
    end else begin
      r.side.spec = 1'b0;
      r.side.neg  = num[DW];
    end
    return r;
  endfunction

  clamp_t        clk_q, clb_q;
  logic [DW-1:0] dk_q, db_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      clk_q <= cos_prep(numk_q, denk_q);
      clb_q <= cos_prep(numb_q, denb_q);
      dk_q  <= denk_q;
      db_q  <= denb_q;
    end
  end

  logic [lik_pkg::QW-1:0] qk, qb;
  lik_pkg::cos_side_t     sk_side, sb_side;

  lik_div u_div_knee (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (clk_q.mag),
    .den_i  (dk_q),
    .side_i (clk_q.side),
    .quo_o  (qk),
    .side_o (sk_side)
  );

  lik_div u_div_femur (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (clb_q.mag),
    .den_i  (db_q),
    .side_i (clb_q.side),
    .quo_o  (qb),
    .side_o (sb_side)
  );

  // ---------------- signed cosine and acos sine leg ----------------
  function automatic logic signed [15:0] cos_val(input lik_pkg::cos_side_t sd,
                                                 input logic [lik_pkg::QW-1:0] q);
    logic signed [15:0] m;
    m = sd.spec ? 16'(lik_pkg::ONE_Q14) : {1'b0, q};
    return sd.neg ? -m : m;
  endfunction

  logic signed [15:0] ck_dq [CD_N];
  logic signed [15:0] cb_dq [CD_N];
  logic               flag_dq [FLAG_N];
  logic [31:0]        cksq_q, cbsq_q;
  logic [28:0]        vk_q, vb_q;
  logic [15:0]        sin_k, sin_b;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ck_dq[0]   <= cos_val(sk_side, qk);
      cb_dq[0]   <= cos_val(sb_side, qb);
      flag_dq[0] <= sk_side.spec | sb_side.spec;
      for (int k = 1; k < CD_N; k++) begin
        ck_dq[k] <= ck_dq[k-1];
        cb_dq[k] <= cb_dq[k-1];
      end
      for (int k = 1; k < FLAG_N; k++) flag_dq[k] <= flag_dq[k-1];
      cksq_q <= 32'(ck_dq[0] * ck_dq[0]);
      cbsq_q <= 32'(cb_dq[0] * cb_dq[0]);
      vk_q   <= 29'(32'd268435456 - cksq_q);
      vb_q   <= 29'(32'd268435456 - cbsq_q);
    end
  end

  lik_sqrt u_sqrt_knee (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  ({3'b0, vk_q}),
    .root_o (sin_k)
  );

  lik_sqrt u_sqrt_femur (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  ({3'b0, vb_q}),
    .root_o (sin_b)
  );

  logic signed [AW-1:0] acos_k, acos_b;

  lik_cordic u_cordic_knee (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ({{(CIW-16){1'b0}}, sin_k}),
    .x_i   ({{(CIW-16){ck_dq[CD_N-1][15]}}, ck_dq[CD_N-1]}),
    .ang_o (acos_k)
  );

  lik_cordic u_cordic_femur (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ({{(CIW-16){1'b0}}, sin_b}),
    .x_i   ({{(CIW-16){cb_dq[CD_N-1][15]}}, cb_dq[CD_N-1]}),
    .ang_o (acos_b)
  );

  // ---------------- angle alignment ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      hip_dq[0] <= hip_ang;
      zp_dq[0]  <= zp_ang;
      for (int k = 1; k < HIP_D; k++) hip_dq[k] <= hip_dq[k-1];
      for (int k = 1; k < ZP_D; k++) zp_dq[k] <= zp_dq[k-1];
    end
  end

  // ---------------- output register ----------------
  logic signed [AW:0] knee_sum, femur_sum;
  logic [1:0]         tag_q;
  logic signed [15:0] hip_q, femur_q13, knee_q13;
  logic               unr_q;

  assign knee_sum  = (AW+1)'(lik_pkg::PI_S24) - (AW+1)'(acos_k);
  assign femur_sum = (AW+1)'(zp_dq[ZP_D-1]) + (AW+1)'(acos_b);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q     <= tag_dq[T_ACOS];
      hip_q     <= lik_pkg::to_q13((AW+1)'(hip_dq[HIP_D-1]));
      femur_q13 <= lik_pkg::to_q13(femur_sum);
      knee_q13  <= lik_pkg::to_q13(knee_sum);
      unr_q     <= flag_dq[FLAG_N-1];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign leg_tag_out_o = tag_q;
  assign hip_yaw_o     = hip_q;
  assign femur_angle_o = femur_q13;
  assign knee_angle_o  = knee_q13;
  assign unreachable_o = unr_q;

  // ---------------- assertions ----------------
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_knee_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[T_C] && !flag_dq[0]) |-> (ck_dq[0] <= 16'sd16384 && ck_dq[0] >= -16'sd16384))
    else $error("knee cosine out of range without clamp");

  a_femur_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[T_C] && !flag_dq[0]) |-> (cb_dq[0] <= 16'sd16384 && cb_dq[0] >= -16'sd16384))
    else $error("femur cosine out of range without clamp");

endmodule
